>>> src/enru_pkg.sv
// ----------------------------------------------------------------------------
// enru_pkg
// Types and constants shared by the elastic-net regularizer controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package enru_pkg;

   localparam int VALUE_W    = 32;
   localparam int THRESH_W   = 31;
   localparam int STRENGTH_W = 24;
   localparam int MIX_W      = 17;
   localparam int PEN_W      = 63;
   localparam int SUM_W      = 64;
   localparam int MAG_W      = 32;
   localparam int PROD_W     = 64;
   localparam int Y_W        = 40;
   localparam int QUO_W      = 32;
   localparam int CNT_W      = 5;
   localparam int CSR_W      = 24;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_STRENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_RATIO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIDGE     = 2'd2;

   localparam logic [MIX_W-1:0]   ALPHA_ONE    = 17'd65536;
   localparam logic [PEN_W-1:0]   PEN_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] GRAD_POS_LIM = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] GRAD_NEG_LIM = 32'h8000_0000;

   typedef struct packed {
      logic                       kind;
      logic signed [VALUE_W-1:0]  value;
      logic [THRESH_W-1:0]        threshold;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  gradient;
      logic signed [VALUE_W-1:0]  shrunk;
      logic [PEN_W-1:0]           penalty;
      logic                       penalty_valid;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ,
      ST_BMAG,
      ST_INNER,
      ST_GMUL,
      ST_GRND,
      ST_L1LD,
      ST_L1MUL,
      ST_T1,
      ST_L2LD,
      ST_L2MUL,
      ST_T2,
      ST_PEN,
      ST_DIFF,
      ST_DLOAD,
      ST_DIV,
      ST_QRND,
      ST_SHRUNK,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SUM,
      OP_INNER,
      OP_L1_LOAD,
      OP_L2_LOAD,
      OP_MAC,
      OP_GRAD,
      OP_T1,
      OP_T2,
      OP_PEN,
      OP_DIFF,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_QROUND,
      OP_SHRUNK,
      OP_RSP
   } op_type;

   typedef enum logic [1:0] {
      MUL_SQ,
      MUL_BMAG,
      MUL_SA,
      MUL_SB
   } mul_sel_type;

   typedef struct packed {
      op_type      op;
      logic        mul_en;
      mul_sel_type mul_sel;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic y_zero;
      logic div_done;
      logic diff_zero;
   } status_type;

endpackage

>>> src/enru_datapath.sv
// ----------------------------------------------------------------------------
// enru_datapath
// Configuration registers, running sums, a shared 32x32 multiplier, a
// shift-add multiplier for the wide products, a restoring divider and the
// result register. Every step is selected by the controller's command.
// ----------------------------------------------------------------------------
module enru_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  enru_pkg::req_type                    req_data,
   input  logic                                 csr_wr_en,
   input  logic [enru_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [enru_pkg::CSR_W-1:0]           csr_wdata,
   input  enru_pkg::cmd_type                    cmd,
   output enru_pkg::status_type                 status,
   output enru_pkg::rsp_type                    rsp_data
);
   import enru_pkg::*;

   localparam int SHIFT   = FRAC_BITS + 16;
   localparam int SHIFT2  = 2 * FRAC_BITS + 16;
   localparam int INNER_W = ((FRAC_BITS + MIX_W) > 49 ? FRAC_BITS + MIX_W : 49) + 1;
   localparam int ACC_W   = ((INNER_W + STRENGTH_W) > (Y_W + SUM_W) ?
                             INNER_W + STRENGTH_W : Y_W + SUM_W) + 1;
   localparam int RND_W   = ACC_W + 1;
   localparam int DIV_W   = (SHIFT > Y_W ? SHIFT : Y_W) + 1;
   localparam int N_W     = QUO_W + SHIFT;

   // Configuration
   logic [STRENGTH_W-1:0] strength_ff, strength_in;
   logic [MIX_W-1:0]      mix_ratio_ff, mix_ratio_in;
   logic                  ridge_mode_ff, ridge_mode_in;

   // Running sums
   logic [SUM_W-1:0]      abs_sum_ff, abs_sum_in;
   logic [SUM_W-1:0]      square_sum_ff, square_sum_in;

   // Item
   logic                  kind_ff, kind_in;
   logic                  last_ff, last_in;
   logic                  neg_ff, neg_in;
   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic [THRESH_W-1:0]   thresh_ff, thresh_in;

   // Arithmetic
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [ACC_W-1:0]      x_ff, x_in;
   logic [Y_W-1:0]        y_ff, y_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [VALUE_W-1:0]    grad_ff, grad_in;
   logic [PEN_W-1:0]      t1_ff, t1_in;
   logic [PEN_W-1:0]      t2_ff, t2_in;
   logic [PEN_W-1:0]      pen_ff, pen_in;
   logic [MAG_W-1:0]      diff_ff, diff_in;
   logic                  diff_zero_ff, diff_zero_in;
   logic [DIV_W-1:0]      d_ff, d_in;
   logic [DIV_W-1:0]      r_ff, r_in;
   logic [QUO_W-1:0]      q_ff, q_in;
   logic [QUO_W:0]        qr_ff, qr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_W-1:0]    shrunk_ff, shrunk_in;
   rsp_type               rsp_ff, rsp_in;

   // Combinational helpers
   logic [MIX_W-1:0]      alpha;
   logic [MIX_W-1:0]      beta;
   logic [MAG_W-1:0]      value_u;
   logic [MAG_W-1:0]      mul_a;
   logic [MAG_W-1:0]      mul_b;
   logic [SUM_W:0]        abs_wide;
   logic [SUM_W:0]        square_wide;
   logic [INNER_W-1:0]    inner;
   logic [RND_W-1:0]      rnd1_q;
   logic [RND_W-1:0]      rnd2_q;
   logic [RND_W-1:0]      grad_lim;
   logic [VALUE_W-1:0]    grad_mag;
   logic [PEN_W:0]        pen_wide;
   logic [MAG_W-1:0]      t_eff;
   logic [N_W-1:0]        n_full;
   logic [DIV_W:0]        r_shift;
   logic                  r_ge;
   logic                  half_ge;
   logic [MAG_W-1:0]      q_clamp;

   assign alpha   = (mix_ratio_ff > ALPHA_ONE) ? ALPHA_ONE : mix_ratio_ff;
   assign beta    = ALPHA_ONE - alpha;
   assign value_u = $unsigned(req_data.value);

   // Shared narrow multiplier: operand choice per step.
   always_comb begin
      case (cmd.mul_sel)
         MUL_SQ: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         MUL_BMAG: begin
            mul_a = MAG_W'(beta);
            mul_b = mag_ff;
         end
         MUL_SA: begin
            mul_a = MAG_W'(strength_ff);
            mul_b = MAG_W'(alpha);
         end
         default: begin
            mul_a = MAG_W'(strength_ff);
            mul_b = MAG_W'(beta);
         end
      endcase
   end

   assign abs_wide    = {1'b0, abs_sum_ff} + (SUM_W + 1)'(mag_ff);
   assign square_wide = {1'b0, square_sum_ff} + {1'b0, prod_ff};

   // Gradient inner term (magnitude): alpha*2^F + 2*beta*|c|, zero for a zero coefficient.
   assign inner = (mag_ff != '0) ?
                  (INNER_W'(alpha) << FRAC_BITS) + (INNER_W'(prod_ff) << 1) : '0;

   // Round to nearest, ties away from zero, at both penalty scalings.
   assign rnd1_q = ({1'b0, acc_ff} + (RND_W'(1) << (SHIFT - 1))) >> SHIFT;
   assign rnd2_q = ({1'b0, acc_ff} + (RND_W'(1) << (SHIFT2 - 1))) >> SHIFT2;

   assign grad_lim = neg_ff ? RND_W'(GRAD_NEG_LIM) : RND_W'(GRAD_POS_LIM);
   assign grad_mag = (rnd1_q > grad_lim) ? grad_lim[VALUE_W-1:0] : rnd1_q[VALUE_W-1:0];

   assign pen_wide = {1'b0, t1_ff} + {1'b0, t2_ff};

   assign t_eff   = ridge_mode_ff ? '0 : MAG_W'(thresh_ff);
   assign n_full  = {diff_ff, {SHIFT{1'b0}}};
   assign r_shift = {r_ff, q_ff[QUO_W-1]};
   assign r_ge    = r_shift >= {1'b0, d_ff};
   assign half_ge = {r_ff, 1'b0} >= {1'b0, d_ff};
   assign q_clamp = (qr_ff > {1'b0, diff_ff}) ? diff_ff : qr_ff[MAG_W-1:0];

   // Configuration writes
   always_comb begin
      strength_in   = strength_ff;
      mix_ratio_in  = mix_ratio_ff;
      ridge_mode_in = ridge_mode_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_STRENGTH:  strength_in   = csr_wdata[STRENGTH_W-1:0];
            CSR_MIX_RATIO: mix_ratio_in  = csr_wdata[MIX_W-1:0];
            CSR_RIDGE:     ridge_mode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Step decode
   always_comb begin
      abs_sum_in    = abs_sum_ff;
      square_sum_in = square_sum_ff;
      kind_in       = kind_ff;
      last_in       = last_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      thresh_in     = thresh_ff;
      prod_in       = cmd.mul_en ? PROD_W'(mul_a * mul_b) : prod_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      acc_in        = acc_ff;
      grad_in       = grad_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      pen_in        = pen_ff;
      diff_in       = diff_ff;
      diff_zero_in  = diff_zero_ff;
      d_in          = d_ff;
      r_in          = r_ff;
      q_in          = q_ff;
      qr_in         = qr_ff;
      cnt_in        = cnt_ff;
      shrunk_in     = shrunk_ff;
      rsp_in        = rsp_ff;

      unique case (cmd.op)
         OP_LOAD: begin
            kind_in   = req_data.kind;
            last_in   = req_data.last;
            neg_in    = req_data.value[VALUE_W-1];
            mag_in    = req_data.value[VALUE_W-1] ? (MAG_W'(0) - value_u) : value_u;
            thresh_in = req_data.threshold;
         end
         OP_SUM: begin
            abs_sum_in    = abs_wide[SUM_W] ? '1 : abs_wide[SUM_W-1:0];
            square_sum_in = square_wide[SUM_W] ? '1 : square_wide[SUM_W-1:0];
         end
         OP_INNER: begin
            x_in   = ACC_W'(inner);
            y_in   = Y_W'(strength_ff);
            acc_in = '0;
         end
         OP_L1_LOAD: begin
            x_in   = ACC_W'(abs_sum_ff);
            y_in   = prod_ff[Y_W-1:0];
            acc_in = '0;
         end
         OP_L2_LOAD: begin
            x_in   = ACC_W'(square_sum_ff);
            y_in   = prod_ff[Y_W-1:0];
            acc_in = '0;
         end
         OP_MAC: begin
            if (y_ff[0]) begin
               acc_in = acc_ff + x_ff;
            end
            x_in = x_ff << 1;
            y_in = y_ff >> 1;
         end
         OP_GRAD: begin
            grad_in = neg_ff ? (VALUE_W'(0) - grad_mag) : grad_mag;
         end
         OP_T1: begin
            t1_in = (rnd1_q > RND_W'(PEN_MAX)) ? PEN_MAX : rnd1_q[PEN_W-1:0];
         end
         OP_T2: begin
            t2_in = (rnd2_q > RND_W'(PEN_MAX)) ? PEN_MAX : rnd2_q[PEN_W-1:0];
         end
         OP_PEN: begin
            pen_in        = (pen_wide > (PEN_W + 1)'(PEN_MAX)) ? PEN_MAX : pen_wide[PEN_W-1:0];
            abs_sum_in    = '0;
            square_sum_in = '0;
         end
         OP_DIFF: begin
            diff_zero_in = !(mag_ff > t_eff);
            diff_in      = mag_ff - t_eff;
         end
         OP_DIV_LOAD: begin
            // The quotient never exceeds the difference, so the top part of
            // the shifted dividend already sits below the divisor.
            d_in   = (DIV_W'(1) << SHIFT) + DIV_W'(prod_ff[Y_W-1:0]);
            r_in   = DIV_W'(n_full >> QUO_W);
            q_in   = n_full[QUO_W-1:0];
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            r_in   = r_ge ? DIV_W'(r_shift - {1'b0, d_ff}) : DIV_W'(r_shift);
            q_in   = {q_ff[QUO_W-2:0], r_ge};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_QROUND: begin
            qr_in = {1'b0, q_ff} + (QUO_W + 1)'(half_ge);
         end
         OP_SHRUNK: begin
            if (diff_zero_ff) begin
               shrunk_in = '0;
            end else begin
               shrunk_in = neg_ff ? (VALUE_W'(0) - q_clamp) : q_clamp;
            end
         end
         OP_RSP: begin
            rsp_in.gradient      = kind_ff ? '0 : $signed(grad_ff);
            rsp_in.shrunk        = kind_ff ? $signed(shrunk_ff) : '0;
            rsp_in.penalty_valid = !kind_ff && last_ff;
            rsp_in.penalty       = (!kind_ff && last_ff) ? pen_ff : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff   <= '0;
         mix_ratio_ff  <= '0;
         ridge_mode_ff <= 1'b0;
         abs_sum_ff    <= '0;
         square_sum_ff <= '0;
      end else begin
         strength_ff   <= strength_in;
         mix_ratio_ff  <= mix_ratio_in;
         ridge_mode_ff <= ridge_mode_in;
         abs_sum_ff    <= abs_sum_in;
         square_sum_ff <= square_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      last_ff      <= last_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      thresh_ff    <= thresh_in;
      prod_ff      <= prod_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      acc_ff       <= acc_in;
      grad_ff      <= grad_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      pen_ff       <= pen_in;
      diff_ff      <= diff_in;
      diff_zero_ff <= diff_zero_in;
      d_ff         <= d_in;
      r_ff         <= r_in;
      q_ff         <= q_in;
      qr_ff        <= qr_in;
      cnt_ff       <= cnt_in;
      shrunk_ff    <= shrunk_in;
      rsp_ff       <= rsp_in;
   end

   assign status.last      = last_ff;
   assign status.y_zero    = (y_ff == '0);
   assign status.div_done  = (cnt_ff == CNT_W'(QUO_W - 1));
   assign status.diff_zero = diff_zero_ff;

   assign rsp_data = rsp_ff;

endmodule

>>> src/enru_ctrl.sv
// ----------------------------------------------------------------------------
// enru_ctrl
// Sequencer for the regularizer: takes one item at a time, steps the
// datapath through the gradient, penalty or soft-threshold sequence and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module enru_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  enru_pkg::status_type  status,
   output enru_pkg::cmd_type     cmd
);
   import enru_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // The result register may be refilled when empty or emptied this cycle.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;
      cmd.op       = OP_NONE;
      cmd.mul_en   = 1'b0;
      cmd.mul_sel  = MUL_SQ;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = req_kind ? ST_DIFF : ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SQ;
            state_in    = ST_BMAG;
         end
         ST_BMAG: begin
            cmd.op      = OP_SUM;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_BMAG;
            state_in    = ST_INNER;
         end
         ST_INNER: begin
            cmd.op   = OP_INNER;
            state_in = ST_GMUL;
         end
         ST_GMUL: begin
            if (status.y_zero) begin
               state_in = ST_GRND;
            end else begin
               cmd.op = OP_MAC;
            end
         end
         ST_GRND: begin
            cmd.op      = OP_GRAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SA;
            state_in    = status.last ? ST_L1LD : ST_DONE;
         end
         ST_L1LD: begin
            // The lambda*beta product computed here is kept for the L2 term.
            cmd.op      = OP_L1_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SB;
            state_in    = ST_L1MUL;
         end
         ST_L1MUL: begin
            if (status.y_zero) begin
               state_in = ST_T1;
            end else begin
               cmd.op = OP_MAC;
            end
         end
         ST_T1: begin
            cmd.op   = OP_T1;
            state_in = ST_L2LD;
         end
         ST_L2LD: begin
            cmd.op   = OP_L2_LOAD;
            state_in = ST_L2MUL;
         end
         ST_L2MUL: begin
            if (status.y_zero) begin
               state_in = ST_T2;
            end else begin
               cmd.op = OP_MAC;
            end
         end
         ST_T2: begin
            cmd.op   = OP_T2;
            state_in = ST_PEN;
         end
         ST_PEN: begin
            cmd.op   = OP_PEN;
            state_in = ST_DONE;
         end
         ST_DIFF: begin
            cmd.op      = OP_DIFF;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SB;
            state_in    = ST_DLOAD;
         end
         ST_DLOAD: begin
            cmd.op   = OP_DIV_LOAD;
            state_in = status.diff_zero ? ST_SHRUNK : ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (status.div_done) begin
               state_in = ST_QRND;
            end
         end
         ST_QRND: begin
            cmd.op   = OP_QROUND;
            state_in = ST_SHRUNK;
         end
         ST_SHRUNK: begin
            cmd.op   = OP_SHRUNK;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.op       = OP_RSP;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/elastic_net_regularizer_unit.sv
// ----------------------------------------------------------------------------
// elastic_net_regularizer_unit
// Elastic-net regularizer in signed fixed point with FRAC_BITS fraction bits.
// One item is worked on at a time and gives one result. A coefficient item
// steps a bit-serial shift-add multiplier over the bits of strength (up to
// 24); an item that closes a vector adds two more passes of that multiplier
// over the bit lengths of lambda*alpha and lambda*(1 - alpha) (79 together
// at most). A soft-threshold item runs the one-bit-per-cycle restoring
// divider (32 steps), which is skipped when the value lies inside the
// threshold. A new item is taken while the previous result still waits in
// the output register.
// ----------------------------------------------------------------------------
module elastic_net_regularizer_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  enru_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output enru_pkg::rsp_type                rsp_data,
   input  logic                             csr_wr_en,
   input  logic [enru_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [enru_pkg::CSR_W-1:0]       csr_wdata
);
   import enru_pkg::*;

   cmd_type    cmd;
   status_type status;

   enru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   enru_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // An accepted item keeps the block busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an accepted item");

   // A result is never written over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RSP) |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

   // A new result only appears at the end of work on an item.
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in progress");
`endif

endmodule

>>> tb/elastic_net_regularizer_unit_tb.sv
// ----------------------------------------------------------------------------
// elastic_net_regularizer_unit_tb
// Self-checking bench for the elastic-net regularizer. Every accepted item is
// run through a bit-exact predictor of gradient, vector penalty and soft
// threshold, and each result is compared field by field with the oldest
// prediction. Directed corner cases come first, then random coefficient
// vectors mixed with soft-threshold requests over several register settings
// and idling patterns, and finally a long receiver hold-off.
// ----------------------------------------------------------------------------
module elastic_net_regularizer_unit_tb;
   import enru_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int LONG_HOLD = 400;
   localparam logic KIND_COEF = 1'b0;
   localparam logic KIND_SHRINK = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   // Copies of the registers and running sums as the block should hold them.
   logic [STRENGTH_W-1:0] lambda_q = '0;
   logic [MIX_W-1:0]      mix_q = '0;
   logic                  ridge_q = 1'b0;
   logic [SUM_W-1:0]      abs_total = '0;
   logic [SUM_W-1:0]      square_total = '0;

   rsp_type expected_rsps[$];
   int      error_count = 0;
   int      items_sent = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      hold_left = 0;

   elastic_net_regularizer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // (x + half) >> sh, clipped to lim.
   function automatic logic [63:0] round_sat(input logic [127:0] x, input int unsigned sh,
                                             input logic [63:0] lim);
      logic [128:0] y;
      y = ({1'b0, x} + (129'd1 << (sh - 1))) >> sh;
      return (y > 129'(lim)) ? lim : y[63:0];
   endfunction

   function automatic rsp_type predict_item(input req_type item);
      rsp_type      res;
      logic [31:0]  raw;
      logic [32:0]  mag;
      logic [MIX_W-1:0] alpha;
      logic [MIX_W-1:0] beta;
      logic [63:0]  inner;
      logic [63:0]  grad;
      logic [63:0]  t1;
      logic [63:0]  t2;
      logic [64:0]  wide_sum;
      logic [31:0]  level;
      logic [31:0]  diff;
      logic [63:0]  divisor;
      logic [63:0]  num;
      logic [63:0]  quot;
      logic [63:0]  rem;
      res = '0;
      raw = item.value;
      mag = raw[31] ? {1'b0, ~raw} + 33'd1 : {1'b0, raw};
      alpha = (mix_q > ALPHA_ONE) ? ALPHA_ONE : mix_q;
      beta = ALPHA_ONE - alpha;
      if (item.kind == KIND_COEF) begin
         // A zero coefficient has a zero L1 subgradient as well.
         inner = (mag == 33'd0) ? 64'd0
               : (64'(alpha) << FRAC_BITS) + 64'(beta) * 64'd2 * 64'(mag);
         grad = round_sat(128'(lambda_q) * 128'(inner), FRAC_BITS + 16,
                          raw[31] ? 64'(GRAD_NEG_LIM) : 64'(GRAD_POS_LIM));
         res.gradient = raw[31] ? -grad[31:0] : grad[31:0];
         wide_sum = {1'b0, abs_total} + 65'(mag);
         abs_total = wide_sum[64] ? '1 : wide_sum[63:0];
         wide_sum = {1'b0, square_total} + 65'(mag) * 65'(mag);
         square_total = wide_sum[64] ? '1 : wide_sum[63:0];
         if (item.last) begin
            t1 = round_sat(128'(lambda_q) * 128'(alpha) * 128'(abs_total),
                           FRAC_BITS + 16, 64'(PEN_MAX));
            t2 = round_sat(128'(lambda_q) * 128'(beta) * 128'(square_total),
                           2 * FRAC_BITS + 16, 64'(PEN_MAX));
            t1 = t1 + t2;
            res.penalty = (t1 > 64'(PEN_MAX)) ? PEN_MAX : t1[62:0];
            res.penalty_valid = 1'b1;
            abs_total = '0;
            square_total = '0;
         end
      end else begin
         level = ridge_q ? 32'd0 : {1'b0, item.threshold};
         if (mag > 33'(level)) begin
            diff = 32'(mag - 33'(level));
            divisor = (64'd1 << (FRAC_BITS + 16)) + 64'(lambda_q) * 64'(beta);
            num = 64'(diff) << (FRAC_BITS + 16);
            quot = num / divisor;
            rem = num % divisor;
            if (64'd2 * rem >= divisor) quot = quot + 64'd1;
            if (quot > 64'(diff)) quot = 64'(diff);
            res.shrunk = raw[31] ? -quot[31:0] : quot[31:0];
         end
      end
      return res;
   endfunction

   function automatic logic [31:0] rand_value();
      logic [31:0] bits;
      logic [31:0] pick;
      bits = $urandom;
      case ($urandom_range(0, 5))
         0: pick = {{12{bits[19]}}, bits[19:0]};
         1: pick = {{8{bits[23]}}, bits[23:0]};
         2: begin
            case ($urandom_range(0, 4))
               0: pick = 32'h8000_0000;
               1: pick = 32'h7FFF_FFFF;
               2: pick = '0;
               3: pick = 32'h0000_0001;
               default: pick = '1;
            endcase
         end
         default: pick = bits;
      endcase
      return pick;
   endfunction

   // Thresholds cluster around the magnitude of the value so that both sides
   // of the dead zone and the boundary itself are hit often.
   function automatic logic [30:0] rand_level(input logic [31:0] v);
      logic [32:0] mag;
      logic [32:0] near;
      logic [30:0] pick;
      mag = v[31] ? {1'b0, ~v} + 33'd1 : {1'b0, v};
      near = mag + 33'($urandom_range(0, 4)) - 33'd2;
      case ($urandom_range(0, 5))
         0: pick = '0;
         1: pick = '1;
         2, 3: pick = (near > 33'h7FFF_FFFF) ? '1 : near[30:0];
         4: pick = mag[31:1];
         default: pick = 31'($urandom);
      endcase
      return pick;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so that a following item goes out back to back.
   task automatic send_item(input logic kind, input logic [31:0] value,
                            input logic [30:0] level, input logic last);
      req_type item;
      item.kind = kind;
      item.value = value;
      item.threshold = level;
      item.last = last;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsps.insert(expected_rsps.size(), predict_item(item));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Changed at a rising edge so that the stall process never races with it.
   task automatic set_idling(input int send_pct, input int recv_pct);
      wait_drain();
      @(posedge clock);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // Upper data bits beyond each register's width are filled with noise.
   task automatic configure(input logic [STRENGTH_W-1:0] lambda, input logic [MIX_W-1:0] mix,
                            input logic ridge);
      write_csr(CSR_STRENGTH, lambda);
      write_csr(CSR_MIX_RATIO, {7'($urandom), mix});
      write_csr(CSR_RIDGE, {23'($urandom), ridge});
      write_csr(CSR_UNUSED, CSR_W'($urandom));
      lambda_q = lambda;
      mix_q = mix;
      ridge_q = ridge;
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_vector();
      int          len;
      logic [31:0] v;
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            v = rand_value();
            send_item(KIND_SHRINK, v, rand_level(v), 1'($urandom));
         end
         v = rand_value();
         send_item(KIND_COEF, v, 31'($urandom), k == len - 1);
      end
   endtask

   task automatic test_reset_defaults();
      // Registers still hold their reset values: lambda is zero.
      send_item(KIND_COEF, 32'h0003_0000, 31'h0, 1'b0);
      send_item(KIND_COEF, 32'hFFFE_0000, 31'h0, 1'b1);
      send_item(KIND_SHRINK, 32'h0005_0000, 31'h0001_0000, 1'b0);
      wait_drain();
   endtask

   task automatic test_directed_cases();
      configure(24'h01_0000, 17'd32768, 1'b0);
      send_item(KIND_COEF, 32'h0000_0000, 31'h0, 1'b0);
      send_item(KIND_COEF, 32'h7FFF_FFFF, '1, 1'b0);
      send_item(KIND_COEF, 32'h8000_0000, 31'h0, 1'b0);
      send_item(KIND_COEF, 32'h0000_0001, 31'h0, 1'b0);
      // The last flag on a soft-threshold item must leave the sums alone.
      send_item(KIND_SHRINK, 32'h0003_0000, 31'h0001_0000, 1'b1);
      send_item(KIND_COEF, 32'hFFFF_FFFF, 31'h0, 1'b1);
      // A vector of one item straight after a clear.
      send_item(KIND_COEF, 32'h0001_0000, 31'h0, 1'b1);
      send_item(KIND_SHRINK, 32'hFFFD_0000, 31'h0001_0000, 1'b0);
      send_item(KIND_SHRINK, 32'h0000_8000, 31'h0001_0000, 1'b0);
      send_item(KIND_SHRINK, 32'h0001_0000, 31'h0001_0000, 1'b0);
      send_item(KIND_SHRINK, 32'h8000_0000, 31'h0, 1'b0);
      send_item(KIND_SHRINK, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      wait_drain();
      // Alpha above one is clamped to pure lasso; ridge mode drops the threshold.
      configure(24'hFF_FFFF, 17'h1_FFFF, 1'b1);
      send_item(KIND_COEF, 32'h7FFF_FFFF, 31'h0, 1'b0);
      send_item(KIND_COEF, 32'h8000_0000, 31'h0, 1'b1);
      send_item(KIND_SHRINK, 32'hFFFB_0000, 31'h7FFF_FFFF, 1'b0);
      wait_drain();
      // Pure ridge with the largest lambda drives the gradient into saturation.
      configure(24'hFF_FFFF, 17'd0, 1'b0);
      send_item(KIND_COEF, 32'h7FFF_FFFF, 31'h0, 1'b0);
      send_item(KIND_COEF, 32'h8000_0000, 31'h0, 1'b0);
      send_item(KIND_SHRINK, 32'h7FFF_FFFF, 31'h0, 1'b1);
      send_item(KIND_COEF, 32'h0000_3039, 31'h0, 1'b1);
      wait_drain();
   endtask

   task automatic run_setting(input int sel);
      int start;
      wait_drain();
      case (sel)
         0: configure(24'($urandom), 17'($urandom_range(0, ALPHA_ONE)), 1'b0);
         1: configure(24'hFF_FFFF, ALPHA_ONE, 1'b0);
         2: configure(24'($urandom_range(1, 24'h03_FFFF)), 17'd0, 1'b1);
         3: configure(24'($urandom), 17'($urandom_range(ALPHA_ONE + 1, 17'h1_FFFF)), 1'b0);
         4: configure(24'h00_0000, 17'($urandom_range(0, ALPHA_ONE)), 1'b1);
         5: configure(24'($urandom), 17'($urandom_range(0, ALPHA_ONE)), 1'($urandom));
         6: configure(24'h00_0001, 17'd1, 1'b0);
         default: configure(24'($urandom), 17'($urandom), 1'($urandom));
      endcase
      start = items_sent;
      while (items_sent - start < 60) send_random_vector();
   endtask

   task automatic test_idling_phases();
      set_idling(0, 0);
      run_setting(0);
      run_setting(1);
      set_idling(75, 0);
      run_setting(2);
      run_setting(3);
      set_idling(0, 75);
      run_setting(4);
      run_setting(5);
      set_idling(27, 27);
      run_setting(6);
      run_setting(7);
   endtask

   // The receiver holds off while items keep coming, so the block backs up
   // and must stall its input; afterwards everything has to drain in order.
   task automatic test_long_hold();
      set_idling(0, 0);
      configure(24'($urandom), 17'($urandom_range(0, ALPHA_ONE)), 1'b0);
      @(posedge clock);
      hold_left = LONG_HOLD;
      @(negedge clock);
      repeat (3) send_random_vector();
      wait_drain();
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("result %h with no item outstanding", rsp_data));
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.gradient !== want.gradient)
               report_mismatch($sformatf("gradient %h, expected %h",
                                         rsp_data.gradient, want.gradient));
            if (rsp_data.shrunk !== want.shrunk)
               report_mismatch($sformatf("shrunk %h, expected %h",
                                         rsp_data.shrunk, want.shrunk));
            if (rsp_data.penalty !== want.penalty)
               report_mismatch($sformatf("penalty %h, expected %h",
                                         rsp_data.penalty, want.penalty));
            if (rsp_data.penalty_valid !== want.penalty_valid)
               report_mismatch($sformatf("penalty_valid %b, expected %b",
                                         rsp_data.penalty_valid, want.penalty_valid));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_cases();
      test_idling_phases();
      test_long_hold();
      wait_drain();
      repeat (120) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
